// ===== design/dvru_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared types, codes and default sizes for the route update core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dvru_pkg;

  // Default sizes for the top-level parameters.
  localparam int DefTableDepth = 32;
  localparam int DefNumLinks   = 4;

  // Link register slots that exist in hardware, whatever NUM_LINKS is.
  localparam int LinkSlots = 4;

  // Field widths.
  localparam int AddrW   = 32;
  localparam int DistW   = 16;
  localparam int CfgIdxW = 4;
  localparam int CfgW    = 32;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // Result codes reported with every route.
  typedef enum logic [1:0] {
    ACT_KEPT    = 2'd0,
    ACT_UPDATED = 2'd1,
    ACT_ADDED   = 2'd2,
    ACT_DROPPED = 2'd3
  } action_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COST,
    ST_SEARCH,
    ST_UPDATE,
    ST_FINISH
  } state_e;

endpackage : dvru_pkg

`default_nettype wire

// ===== design/distance_vector_route_update_core.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route update core
// Routing table with sequential destination search and shortest-path update.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one advertised route
//   per transaction. The output channel (out_valid_o / out_stall_i) returns
//   exactly one result transaction per route, in order. Link neighbors and
//   costs are written through the plain write port (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) while the core is idle; even indexes hold neighbor
//   addresses, odd indexes hold costs, and indexes beyond the last link
//   register are ignored.
//
//   An accepted route passes the cost, search, update (on a hit) and
//   finish states, scanning at most the current fill count of entries.
//   The table memory has one read port and returns one entry per cycle;
//   one equality compare per cycle walks the stored destinations, then
//   the update state decides the distance update.
//   The core takes one route at a time and raises in_stall_o meanwhile.
//
//   The result sits in an output register, so a new route can be accepted
//   while the previous result waits on out_stall_i. A finished route whose
//   result cannot be loaded holds the core in its final state.
//
//   Reset empties the table through the fill count (entries are not
//   cleared), clears the changed flag and all link registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_update_core #(
  parameter int TABLE_DEPTH = dvru_pkg::DefTableDepth,
  parameter int NUM_LINKS   = dvru_pkg::DefNumLinks
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Configuration write port
  input  wire                               cfg_we_i,
  input  wire  [dvru_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [dvru_pkg::CfgW-1:0]         cfg_wdata_i,
  // Input route channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [dvru_pkg::AddrW-1:0]        neighbor_addr_i,
  input  wire  [dvru_pkg::AddrW-1:0]        dest_addr_i,
  input  wire  [dvru_pkg::DistW-1:0]        adv_distance_i,
  input  wire                               last_entry_i,
  // Result channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output dvru_pkg::action_e                 action_o,
  output logic [dvru_pkg::DistW-1:0]        route_distance_o,
  output logic [dvru_pkg::AddrW-1:0]        route_next_hop_o,
  output logic                              table_changed_o,
  output logic                              last_result_o
);

  import dvru_pkg::*;

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  // --------------------------------------------------------------------------
  // Link configuration registers. All four slots exist; only the first
  // NUM_LINKS take part in the cost lookup.
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] link_nb_q   [LinkSlots];
  logic [DistW-1:0] link_cost_q [LinkSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LinkSlots; k++) begin
        link_nb_q[k]   <= '0;
        link_cost_q[k] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CfgIdxW'(2 * LinkSlots))) begin
      if (!cfg_idx_i[0]) begin
        link_nb_q[cfg_idx_i[2:1]] <= cfg_wdata_i[AddrW-1:0];
      end else begin
        link_cost_q[cfg_idx_i[2:1]] <= cfg_wdata_i[DistW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers.
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CntW-1:0]  route_count_q, route_count_d;
  logic             changed_q, changed_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             cmp_valid_q, cmp_valid_d;
  logic [IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             out_valid_q, out_valid_d;

  // Latched route and staged result.
  logic [AddrW-1:0] in_nb_q, in_dst_q;
  logic [DistW-1:0] in_adv_q;
  logic             in_last_q;
  logic [DistW-1:0] cand_q, cand_d;
  action_e          res_action_q, res_action_d;
  logic [DistW-1:0] res_dist_q, res_dist_d;
  logic [AddrW-1:0] res_hop_q, res_hop_d;
  logic             res_set_q, res_set_d;

  // Output register.
  action_e          out_action_q;
  logic [DistW-1:0] out_dist_q;
  logic [AddrW-1:0] out_hop_q;
  logic             out_changed_q, out_changed_d;
  logic             out_last_q;

  // Memory read data and control.
  logic [AddrW-1:0] rd_dest_q, rd_hop_q;
  logic [DistW-1:0] rd_dist_q;
  logic             rd_en;
  logic             wr_dest_en, wr_route_en;
  logic [IdxW-1:0]  wr_addr;

  logic             in_accept;
  logic             out_load;
  logic [DistW-1:0] link_cost;
  logic [DistW:0]   cost_sum;
  logic             dest_hit;
  logic             shorter;
  logic             changed_new;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Link cost lookup: later links override earlier matches.
  always_comb begin
    link_cost = '0;
    for (int k = 0; k < NUM_LINKS; k++) begin
      if (link_nb_q[k] == in_nb_q) begin
        link_cost = link_cost_q[k];
      end
    end
  end

  assign cost_sum = {1'b0, in_adv_q} + {1'b0, link_cost};

  // The single compare unit of the search: stored destination against route.
  assign dest_hit = cmp_valid_q && (rd_dest_q == in_dst_q);
  assign shorter  = (cand_q < rd_dist_q);

  assign changed_new = changed_q | res_set_q;

  always_comb begin
    state_d       = state_q;
    route_count_d = route_count_q;
    changed_d     = changed_q;
    rd_idx_d      = rd_idx_q;
    cmp_valid_d   = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    hit_idx_d     = hit_idx_q;
    cand_d        = cand_q;
    res_action_d  = res_action_q;
    res_dist_d    = res_dist_q;
    res_hop_d     = res_hop_q;
    res_set_d     = res_set_q;
    out_changed_d = out_changed_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_load      = 1'b0;
    rd_en         = 1'b0;
    wr_dest_en    = 1'b0;
    wr_route_en   = 1'b0;
    wr_addr       = route_count_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_COST;
        end
      end

      ST_COST: begin
        // Saturating add of the advertised distance and the link cost.
        cand_d   = cost_sum[DistW] ? DistMax : cost_sum[DistW-1:0];
        rd_idx_d = '0;
        state_d  = ST_SEARCH;
      end

      ST_SEARCH: begin
        // One entry is read per cycle; its compare follows in the next cycle.
        if (dest_hit) begin
          hit_idx_d = cmp_idx_q;
          state_d   = ST_UPDATE;
        end else if (rd_idx_q < route_count_q) begin
          rd_en       = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_idx_d   = rd_idx_q[IdxW-1:0];
          rd_idx_d    = rd_idx_q + CntW'(1);
        end else if (route_count_q < DepthCnt) begin
          // Destination is new: append it at the fill count.
          wr_dest_en    = 1'b1;
          wr_route_en   = 1'b1;
          route_count_d = route_count_q + CntW'(1);
          res_action_d  = ACT_ADDED;
          res_dist_d    = cand_q;
          res_hop_d     = in_nb_q;
          res_set_d     = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          // Table is full: the route is dropped and reported with zeros.
          res_action_d = ACT_DROPPED;
          res_dist_d   = '0;
          res_hop_d    = '0;
          res_set_d    = 1'b0;
          state_d      = ST_FINISH;
        end
      end

      ST_UPDATE: begin
        wr_addr = hit_idx_q;
        if (shorter) begin
          wr_route_en  = 1'b1;
          res_action_d = ACT_UPDATED;
          res_dist_d   = cand_q;
          res_hop_d    = in_nb_q;
          res_set_d    = 1'b1;
        end else begin
          res_action_d = ACT_KEPT;
          res_dist_d   = rd_dist_q;
          res_hop_d    = rd_hop_q;
          res_set_d    = 1'b0;
        end
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // Load the result once the output register is free or draining.
        if (!out_valid_q || !out_stall_i) begin
          out_load      = 1'b1;
          out_valid_d   = 1'b1;
          out_changed_d = changed_new;
          changed_d     = in_last_q ? 1'b0 : changed_new;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count_q <= '0;
      changed_q     <= 1'b0;
      rd_idx_q      <= '0;
      cmp_valid_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      route_count_q <= route_count_d;
      changed_q     <= changed_d;
      rd_idx_q      <= rd_idx_d;
      cmp_valid_q   <= cmp_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_nb_q   <= neighbor_addr_i;
      in_dst_q  <= dest_addr_i;
      in_adv_q  <= adv_distance_i;
      in_last_q <= last_entry_i;
    end
    cmp_idx_q    <= cmp_idx_d;
    hit_idx_q    <= hit_idx_d;
    cand_q       <= cand_d;
    res_action_q <= res_action_d;
    res_dist_q   <= res_dist_d;
    res_hop_q    <= res_hop_d;
    res_set_q    <= res_set_d;
    out_changed_q <= out_changed_d;
    if (out_load) begin
      out_action_q <= res_action_q;
      out_dist_q   <= res_dist_q;
      out_hop_q    <= res_hop_q;
      out_last_q   <= in_last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Routing table memory: one write port, one registered read port.
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] dest_mem [TABLE_DEPTH];
  logic [AddrW-1:0] hop_mem  [TABLE_DEPTH];
  logic [DistW-1:0] dist_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_dest_en) begin
      dest_mem[wr_addr] <= in_dst_q;
    end
    if (wr_route_en) begin
      hop_mem[wr_addr]  <= in_nb_q;
      dist_mem[wr_addr] <= cand_q;
    end
    if (rd_en) begin
      rd_dest_q <= dest_mem[rd_idx_q[IdxW-1:0]];
      rd_hop_q  <= hop_mem[rd_idx_q[IdxW-1:0]];
      rd_dist_q <= dist_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign action_o         = out_action_q;
  assign route_distance_o = out_dist_q;
  assign route_next_hop_o = out_hop_q;
  assign table_changed_o  = out_changed_q;
  assign last_result_o    = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    route_count_q <= DepthCnt)
    else $error("route count exceeds table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (route_count_q != $past(route_count_q)) |->
      (route_count_q == $past(route_count_q) + CntW'(1)))
    else $error("route count changed by other than one");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_action_q == ACT_DROPPED)) |->
      ((route_count_q == DepthCnt) && (res_dist_q == '0) && (res_hop_q == '0)))
    else $error("route dropped while table not full or with nonzero fields");

  a_change_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((action_o == ACT_ADDED) || (action_o == ACT_UPDATED))) |->
      table_changed_o)
    else $error("table change not reported");

  a_accept_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_COST))
    else $error("accepted route did not start cost lookup");

endmodule : distance_vector_route_update_core

`default_nettype wire

// ===== dv/distance_vector_route_update_core_tb.sv =====
// ----------------------------------------------------------------------------
// Distance-vector route update core testbench
// Drives advertised routes through the core under changing link settings and
// checks every result transaction against a cycle-free table predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distance_vector_route_update_core_tb;
  import dvru_pkg::*;

  localparam int TableDepth     = DefTableDepth;
  localparam int NumLinks       = DefNumLinks;
  localparam int DestPoolSize   = 40;
  localparam int RandomPhases   = 6;
  localparam int ItemsPerPhase  = 215;
  localparam int DrainCycles    = 60;
  localparam int LongHoldCycles = 400;
  localparam int HoldSpacing    = 600;
  localparam int CycleLimit     = 1000000;
  localparam int MaxReported    = 10;

  // Register map: neighbor and cost registers alternate, one pair per link.
  localparam logic [CfgIdxW-1:0] RegLink0Neighbor = 4'd0;
  localparam logic [CfgIdxW-1:0] RegLink0Cost     = 4'd1;
  localparam logic [CfgIdxW-1:0] RegFirstUnused   = 4'd8;

  // Receiver behavior, picked anew each time the current mode runs out.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PATTERN
  } rx_mode_e;

  typedef struct packed {
    logic [AddrW-1:0] nb;
    logic [AddrW-1:0] dst;
    logic [DistW-1:0] adv;
    logic             last;
  } route_adv_t;

  typedef struct packed {
    action_e          act;
    logic [DistW-1:0] distance;
    logic [AddrW-1:0] hop;
    logic             chg;
    logic             last;
  } route_res_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals that face the core
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgW-1:0]      cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  route_adv_t           cur_adv   = '0;
  logic                 out_stall = 1'b0;

  logic                 in_stall;
  logic                 out_valid;
  action_e              out_action;
  logic [DistW-1:0]     out_distance;
  logic [AddrW-1:0]     out_next_hop;
  logic                 out_changed;
  logic                 out_last;

  distance_vector_route_update_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .neighbor_addr_i  (cur_adv.nb),
    .dest_addr_i      (cur_adv.dst),
    .adv_distance_i   (cur_adv.adv),
    .last_entry_i     (cur_adv.last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .action_o         (out_action),
    .route_distance_o (out_distance),
    .route_next_hop_o (out_next_hop),
    .table_changed_o  (out_changed),
    .last_result_o    (out_last)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the link registers and routing table.
  // Only entries below table_fill are ever looked at.
  // --------------------------------------------------------------------------
  logic [AddrW-1:0] link_nb_q   [LinkSlots];
  logic [DistW-1:0] link_cost_q [LinkSlots];
  logic [AddrW-1:0] rt_dest     [TableDepth];
  logic [AddrW-1:0] rt_hop      [TableDepth];
  logic [DistW-1:0] rt_dist     [TableDepth];
  int unsigned      table_fill;
  logic             adv_changed;

  route_adv_t pending_adverts [$];
  route_res_t expected_routes [$];

  // Link settings for the next programming pass, and the destination pool.
  logic [AddrW-1:0] plan_nb   [LinkSlots];
  logic [DistW-1:0] plan_cost [LinkSlots];
  logic [AddrW-1:0] dest_pool [DestPoolSize];

  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_errors   = 0;
  int unsigned hold_left  = 0;
  int unsigned cycle_count = 0;

  // Works out the result of one advertised route and updates the table copy.
  // The cost comes from the highest-numbered matching link, or 0 without a
  // match; the candidate distance saturates at the largest distance.
  task automatic predict_route_update(input route_adv_t a, output route_res_t r);
    logic [DistW:0]   sum;
    logic [DistW-1:0] cost;
    logic [DistW-1:0] cand;
    int               hit;
    cost = '0;
    for (int k = 0; k < NumLinks; k++) begin
      if (link_nb_q[k] == a.nb) cost = link_cost_q[k];
    end
    sum  = {1'b0, a.adv} + {1'b0, cost};
    cand = sum[DistW] ? DistMax : sum[DistW-1:0];
    hit  = -1;
    for (int i = 0; i < table_fill; i++) begin
      if (hit < 0 && rt_dest[i] == a.dst) hit = i;
    end
    r.distance = '0;
    r.hop  = '0;
    r.last = a.last;
    if (hit >= 0) begin
      // Only a strictly shorter route replaces the stored one.
      if (cand < rt_dist[hit]) begin
        rt_dist[hit] = cand;
        rt_hop[hit]  = a.nb;
        adv_changed  = 1'b1;
        r.act        = ACT_UPDATED;
      end else begin
        r.act = ACT_KEPT;
      end
      r.distance = rt_dist[hit];
      r.hop  = rt_hop[hit];
    end else if (table_fill < TableDepth) begin
      rt_dest[table_fill] = a.dst;
      rt_hop[table_fill]  = a.nb;
      rt_dist[table_fill] = cand;
      table_fill++;
      adv_changed = 1'b1;
      r.act  = ACT_ADDED;
      r.distance = cand;
      r.hop  = a.nb;
    end else begin
      // Full table: the route is dropped and reports zero distance and hop.
      r.act = ACT_DROPPED;
    end
    r.chg = adv_changed;
    if (a.last) adv_changed = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers pending routes in bursts with random gaps between them.
  // A route counts as sent at the edge where in_valid is high and the core
  // does not stall; its expected result is queued at that edge.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    route_adv_t next_adv;
    route_res_t predicted;
    logic       fire;
    logic       next_valid;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        predict_route_update(cur_adv, predicted);
        expected_routes.push_back(predicted);
        n_accepted <= n_accepted + 1;
      end
      // The payload only moves when nothing is waiting on the channel.
      if (!in_valid || fire) begin
        next_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_adverts.size() != 0) begin
          next_adv   = pending_adverts.pop_front();
          cur_adv    <= next_adv;
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            // A third of the bursts run straight into the next one.
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expectation and
  // drives the receiver stall from a randomly chosen mode.
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode   = RX_FREE;
  int unsigned mode_left = 0;
  logic [7:0]  rx_pattern = 8'h00;

  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReported) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin
    route_res_t want;
    logic       next_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode   <= RX_FREE;
      mode_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_routes.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          want = expected_routes.pop_front();
          if (out_action !== want.act || out_distance !== want.distance ||
              out_next_hop !== want.hop || out_changed !== want.chg ||
              out_last !== want.last) begin
            note_error($sformatf({"result %0d: expected act=%s dist=%0d hop=%08h ",
                                  "chg=%b last=%b, got act=%s dist=%0d hop=%08h ",
                                  "chg=%b last=%b"},
              n_results, want.act.name(), want.distance, want.hop, want.chg,
              want.last, out_action.name(), out_distance, out_next_hop,
              out_changed, out_last));
          end
        end
      end

      if (mode_left == 0) begin
        rx_mode    <= rx_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 300);
        rx_pattern <= 8'($urandom());
      end else begin
        mode_left  <= mode_left - 1;
        rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
      end

      case (rx_mode)
        RX_FREE:    next_stall = 1'b0;
        RX_LIGHT:   next_stall = ($urandom_range(0, 3) == 0);
        RX_HEAVY:   next_stall = ($urandom_range(0, 3) != 0);
        default:    next_stall = rx_pattern[7];
      endcase
      // A long hold-off overrides the pattern so the core backs up.
      out_stall <= next_stall || (hold_left != 0);
    end
  end

  // Long receiver hold-offs, started at fixed points in the item count while
  // the sender keeps offering routes.
  int unsigned next_hold_at = 250;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      hold_left    <= 0;
      next_hold_at <= 250;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (n_accepted >= next_hold_at) begin
      hold_left    <= LongHoldCycles;
      next_hold_at <= next_hold_at + HoldSpacing;
    end
  end

  // Watchdog: a hung core or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One register write; the predictor copy follows at once since writes
  // only happen while the core is idle.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx < RegFirstUnused) begin
      if (idx[0]) link_cost_q[idx >> 1] = data[DistW-1:0];
      else        link_nb_q[idx >> 1]   = data;
    end
  endtask

  // Writes every link register from the plan, with junk in the unused upper
  // bits of the costs, plus one write to an index past the last register.
  task automatic program_links();
    for (int k = 0; k < LinkSlots; k++) begin
      cfg_write(CfgIdxW'(RegLink0Neighbor + 2 * k), plan_nb[k]);
      cfg_write(CfgIdxW'(RegLink0Cost + 2 * k), {16'($urandom()), plan_cost[k]});
    end
    cfg_write(RegFirstUnused + 4'($urandom_range(0, 7)), $urandom());
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_route(input logic [AddrW-1:0] nb, input logic [AddrW-1:0] dst,
                             input logic [DistW-1:0] adv, input logic last);
    route_adv_t a;
    a.nb   = nb;
    a.dst  = dst;
    a.adv  = adv;
    a.last = last;
    pending_adverts.push_back(a);
  endtask

  // Waits until every route has been sent and answered, then lets the core
  // settle for longer than one route can take.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_adverts.size() != 0 || in_valid || expected_routes.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Skewed toward short distances so that routes keep getting shorter.
  function automatic logic [DistW-1:0] pick_distance();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DistMax;
      2, 3, 4: return DistW'($urandom_range(0, 15));
      5, 6:    return DistW'($urandom_range(0, 255));
      default: return DistW'($urandom());
    endcase
  endfunction

  function automatic logic [AddrW-1:0] pick_neighbor();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return plan_nb[$urandom_range(0, LinkSlots - 1)];
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  localparam logic [AddrW-1:0] NbA  = 32'h0A00_0001;
  localparam logic [AddrW-1:0] NbB  = 32'hC0A8_0101;
  localparam logic [AddrW-1:0] NbC  = 32'h7F00_0001;
  localparam logic [AddrW-1:0] Dst1 = 32'h0A0A_0A00;
  localparam logic [AddrW-1:0] Dst2 = 32'h8000_0000;
  localparam logic [AddrW-1:0] Dst3 = 32'h0000_0001;

  initial begin
    int unsigned      queued;
    int unsigned      adv_len;
    logic [AddrW-1:0] adv_nb;
    logic [AddrW-1:0] dst;
    logic             last;

    for (int k = 0; k < LinkSlots; k++) begin
      link_nb_q[k]   = '0;
      link_cost_q[k] = '0;
    end
    table_fill  = 0;
    adv_changed = 1'b0;
    for (int i = 0; i < DestPoolSize; i++) dest_pool[i] = $urandom();

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // With reset settings every link points at neighbor 0, so all four match
    // and the last one supplies its zero cost.
    @(negedge clk_i);
    queue_route('0, '0, '0, 1'b0);
    wait_drained();

    // Two links share a neighbor so the higher one must win; one link has
    // the largest cost to force saturation.
    plan_nb[0] = NbA;  plan_cost[0] = 16'd10;
    plan_nb[1] = NbB;  plan_cost[1] = DistMax;
    plan_nb[2] = NbA;  plan_cost[2] = 16'd20;
    plan_nb[3] = '1;   plan_cost[3] = 16'd1;
    program_links();

    @(negedge clk_i);
    queue_route(NbA, Dst1, 16'd5, 1'b0);      // added through the higher link
    queue_route(NbC, Dst1, 16'd25, 1'b0);     // no link: equal distance, kept
    queue_route(NbC, Dst1, 16'd24, 1'b0);     // strictly shorter, updated
    queue_route(NbB, Dst2, DistMax, 1'b0);    // saturated add
    queue_route(NbB, Dst2, 16'd1, 1'b0);      // saturates to the stored value
    queue_route('1, '1, 16'hFFFE, 1'b1);      // lands exactly on the maximum
    queue_route(NbC, Dst2, '0, 1'b1);         // fresh advertisement, updated
    queue_route(NbC, Dst3, 16'd100, 1'b0);
    queue_route(NbA, Dst3, 16'd80, 1'b0);     // equal after cost, kept
    queue_route(NbA, Dst3, 16'd90, 1'b1);     // longer, flag from the add stays
    queue_route(NbB, Dst1, '0, 1'b1);         // nothing changes in this one
    queue_route('0, '0, '0, 1'b1);            // neighbor 0 no longer on a link
    queue_route(NbC, '1, DistMax, 1'b0);      // equal to stored, kept
    wait_drained();

    // Random phases: each one reprograms the links, then sends advertisements
    // of a few routes from one neighbor. The destination pool is larger than
    // the table, so the table fills and later new routes are dropped.
    for (int p = 0; p < RandomPhases; p++) begin
      for (int k = 0; k < LinkSlots; k++) begin
        case ($urandom_range(0, 7))
          0:       plan_nb[k] = '0;
          1:       plan_nb[k] = '1;
          2:       plan_nb[k] = (k == 0) ? 32'($urandom()) : plan_nb[k - 1];
          default: plan_nb[k] = $urandom();
        endcase
        plan_cost[k] = pick_distance();
      end
      program_links();

      @(negedge clk_i);
      queued = 0;
      while (queued < ItemsPerPhase) begin
        adv_nb  = pick_neighbor();
        adv_len = $urandom_range(1, 8);
        for (int j = 0; j < adv_len; j++) begin
          dst  = ($urandom_range(0, 9) == 0) ? 32'($urandom())
                                            : dest_pool[$urandom_range(0, DestPoolSize - 1)];
          last = (j == adv_len - 1);
          // Some noise: a broken advertisement with a stray end marker.
          if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
          queue_route(adv_nb, dst, pick_distance(), last);
        end
        queued += adv_len;
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : distance_vector_route_update_core_tb

// ===== distance_vector_route_update_core.f =====
design/dvru_pkg.sv
design/distance_vector_route_update_core.sv
dv/distance_vector_route_update_core_tb.sv
